/* rtl/hpd_pkg.sv */
// Shared widths, types and helper functions for the homography point distance block.
package hpd_pkg;

   // Configuration and input widths.
   localparam int COEF_W     = 40;
   localparam int PIX_W      = 20;
   localparam int NCOEF      = 8;
   localparam int COEF_IDX_W = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int REQ_W      = 4 * PIX_W;

   // Coefficient register indexes.
   localparam logic [COEF_IDX_W-1:0] COEF_H00 = 3'd0;
   localparam logic [COEF_IDX_W-1:0] COEF_H01 = 3'd1;
   localparam logic [COEF_IDX_W-1:0] COEF_H02 = 3'd2;
   localparam logic [COEF_IDX_W-1:0] COEF_H10 = 3'd3;
   localparam logic [COEF_IDX_W-1:0] COEF_H11 = 3'd4;
   localparam logic [COEF_IDX_W-1:0] COEF_H12 = 3'd5;
   localparam logic [COEF_IDX_W-1:0] COEF_H20 = 3'd6;
   localparam logic [COEF_IDX_W-1:0] COEF_H21 = 3'd7;

   // Projection arithmetic, all Q.28 before the divide.
   localparam int PROD_W    = COEF_W + PIX_W + 1;
   localparam int NUM_W     = 62;
   localparam int MAG_W     = 62;
   localparam int TRANS_SH  = 4;
   localparam int W_ONE_SH  = 28;
   localparam logic signed [NUM_W-1:0] W_ONE = NUM_W'(1) <<< W_ONE_SH;

   // Division: 30 integer bits and 12 fraction bits of quotient.
   localparam int QI_W    = 30;
   localparam int FRAC_W  = 12;
   localparam int QUO_W   = QI_W + FRAC_W;
   localparam int COORD_W = QUO_W + 1;
   localparam int DIFF_W  = QUO_W + 2;
   localparam int NDIV    = 4;

   // Distance: differences below 2^28, squares summed, then root.
   localparam int DMAG_W  = 16 + FRAC_W;
   localparam int SQR_W   = 2 * DMAG_W;
   localparam int SQ_IN_W = SQR_W + 2;
   localparam int ROOT_W  = SQ_IN_W / 2;
   localparam int SREM_W  = ROOT_W + 2;
   localparam int RND_W   = ROOT_W + 1;
   localparam int RND_SH  = 4;
   localparam int DIST_W  = 24;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One queued request: numerators and denominators of both points.
   typedef struct packed {
      logic signed [NUM_W-1:0] nxa;
      logic signed [NUM_W-1:0] nya;
      logic signed [NUM_W-1:0] wa;
      logic signed [NUM_W-1:0] nxb;
      logic signed [NUM_W-1:0] nyb;
      logic signed [NUM_W-1:0] wb;
      logic                    degen;
   } entry_type;

   // Status riding alongside the dividers.
   typedef struct packed {
      logic            valid;
      logic            degen;
      logic            ovf;
      logic [NDIV-1:0] neg;
   } div_side_type;

   // Status riding alongside the distance stages.
   typedef struct packed {
      logic valid;
      logic degen;
      logic sat;
   } tail_side_type;

   // Signed coefficient times unsigned pixel.
   function automatic logic signed [PROD_W-1:0] coef_mul(
      input logic signed [COEF_W-1:0] c,
      input logic        [PIX_W-1:0]  p);
      logic signed [PROD_W-1:0] pe;
      pe = PROD_W'($signed({1'b0, p}));
      coef_mul = PROD_W'(c) * pe;
   endfunction

   // Magnitude of a signed numerator or denominator.
   function automatic logic [MAG_W-1:0] num_mag(input logic signed [NUM_W-1:0] v);
      num_mag = v[NUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

endpackage

/* rtl/hpd_front.sv */
// Front end: coefficient registers, request intake and projective numerators and denominators.
module hpd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [hpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hpd_pkg::COEF_W-1:0]   csr_wdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [hpd_pkg::REQ_W-1:0]    req_tdata,
   output logic                         push_valid,
   output hpd_pkg::entry_type           push_data,
   input  logic                         q_full
);
   import hpd_pkg::*;

   logic signed [COEF_W-1:0] coef_ff [NCOEF];
   logic                     f1_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [12];
   logic signed [PROD_W-1:0] prod_in [12];
   logic                     f2_valid_ff;
   entry_type                f2_ff;
   entry_type                f2_in;
   logic                     front_en;
   logic [PIX_W-1:0]         px [4];

   // Coefficient registers; writes beyond the last index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCOEF; i++) coef_ff[i] <= '0;
      end else if (csr_we && (csr_index < CSR_IDX_W'(NCOEF))) begin
         coef_ff[csr_index[COEF_IDX_W-1:0]] <= $signed(csr_wdata);
      end
   end

   // Both front stages move together whenever the last one can empty.
   assign front_en   = !f2_valid_ff || !q_full;
   assign req_tready = front_en;
   assign push_valid = f2_valid_ff;
   assign push_data  = f2_ff;

   // Unpack pixel coordinates: first x, first y, second x, second y.
   always_comb begin
      for (int i = 0; i < 4; i++) px[i] = req_tdata[i*PIX_W +: PIX_W];
   end

   // Stage one: the twelve coefficient-by-pixel products.
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         prod_in[p*6 + 0] = coef_mul(coef_ff[COEF_H00], px[2*p]);
         prod_in[p*6 + 1] = coef_mul(coef_ff[COEF_H01], px[2*p + 1]);
         prod_in[p*6 + 2] = coef_mul(coef_ff[COEF_H10], px[2*p]);
         prod_in[p*6 + 3] = coef_mul(coef_ff[COEF_H11], px[2*p + 1]);
         prod_in[p*6 + 4] = coef_mul(coef_ff[COEF_H20], px[2*p]);
         prod_in[p*6 + 5] = coef_mul(coef_ff[COEF_H21], px[2*p + 1]);
      end
   end

   // Stage two: sums with translation and the unit term, and the zero-denominator check.
   always_comb begin
      f2_in.nxa = NUM_W'(prod_ff[0]) + NUM_W'(prod_ff[1])
                + (NUM_W'(coef_ff[COEF_H02]) <<< TRANS_SH);
      f2_in.nya = NUM_W'(prod_ff[2]) + NUM_W'(prod_ff[3])
                + (NUM_W'(coef_ff[COEF_H12]) <<< TRANS_SH);
      f2_in.wa  = NUM_W'(prod_ff[4]) + NUM_W'(prod_ff[5]) + W_ONE;
      f2_in.nxb = NUM_W'(prod_ff[6]) + NUM_W'(prod_ff[7])
                + (NUM_W'(coef_ff[COEF_H02]) <<< TRANS_SH);
      f2_in.nyb = NUM_W'(prod_ff[8]) + NUM_W'(prod_ff[9])
                + (NUM_W'(coef_ff[COEF_H12]) <<< TRANS_SH);
      f2_in.wb  = NUM_W'(prod_ff[10]) + NUM_W'(prod_ff[11]) + W_ONE;
      f2_in.degen = (f2_in.wa == '0) || (f2_in.wb == '0);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (front_en) begin
         f1_valid_ff <= req_tvalid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (front_en) begin
         prod_ff <= prod_in;
         f2_ff   <= f2_in;
      end
   end

endmodule

/* rtl/hpd_queue.sv */
// Short request queue between the front end and the back end.
module hpd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  hpd_pkg::entry_type push_data,
   output logic               q_full,
   input  logic               pop,
   output hpd_pkg::entry_type head_data,
   output logic               q_empty
);
   import hpd_pkg::*;

   entry_type           store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                push;
   logic                pull;

   assign q_full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_empty   = (count_ff == '0);
   assign push      = push_valid && !q_full;
   assign pull      = pop && !q_empty;
   assign head_data = store_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pull) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pull) count_ff <= count_ff + 1'b1;
         else if (pull && !push) count_ff <= count_ff - 1'b1;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ptr_ff] <= push_data;
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // A lone push grows the count by one.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pull) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   // Read and write pointers stay apart by the fill count.
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0]))
      else $error("queue pointers disagree with count");

endmodule

/* rtl/hpd_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module hpd_div (
   input  logic                      clock,
   input  logic                      en,
   input  logic [hpd_pkg::MAG_W-1:0] rem_init,
   input  logic [hpd_pkg::QUO_W-1:0] low_bits,
   input  logic [hpd_pkg::MAG_W-1:0] den,
   output logic [hpd_pkg::QUO_W-1:0] quo
);
   import hpd_pkg::*;

   logic [MAG_W-1:0] rem_ff  [QUO_W];
   logic [MAG_W-1:0] den_ff  [QUO_W];
   logic [QUO_W-1:0] bits_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];

   // Each stage brings in one numerator bit and tries one subtract.
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [MAG_W-1:0] rem_prev;
      logic [MAG_W-1:0] den_prev;
      logic [QUO_W-1:0] bits_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [MAG_W:0]   r_try;
      logic [MAG_W:0]   r_sub;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_prev  = rem_init;
         assign den_prev  = den;
         assign bits_prev = low_bits;
         assign quo_prev  = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign bits_prev = bits_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
      end

      assign r_try = {rem_prev, bits_prev[QUO_W-1]};
      assign r_sub = r_try - {1'b0, den_prev};
      assign ge    = (r_try >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? r_sub[MAG_W-1:0] : r_try[MAG_W-1:0];
            den_ff[k]  <= den_prev;
            bits_ff[k] <= bits_prev << 1;
            quo_ff[k]  <= {quo_prev[QUO_W-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

/* rtl/hpd_back.sv */
// Back end: coordinate divides, differences, squares, square root and result register.
module hpd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  hpd_pkg::entry_type        head_data,
   input  logic                      q_empty,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [hpd_pkg::DIST_W-1:0] rsp_tdata,
   output logic [1:0]                rsp_tuser
);
   import hpd_pkg::*;

   logic                en;
   logic signed [NUM_W-1:0] num_sel [NDIV];
   logic signed [NUM_W-1:0] den_sel [NDIV];

   // Stage B0: magnitudes and quotient signs.
   logic                b0_valid_ff;
   logic                b0_degen_ff;
   logic [MAG_W-1:0]    nmag_ff [NDIV];
   logic [MAG_W-1:0]    dmag_ff [NDIV];
   logic [NDIV-1:0]     neg_ff;

   // Stage B1: overflow check and divider operands.
   div_side_type        b1_side_ff;
   logic [MAG_W-1:0]    rinit_ff [NDIV];
   logic [QUO_W-1:0]    low_ff   [NDIV];
   logic [MAG_W-1:0]    dden_ff  [NDIV];
   logic [NDIV-1:0]     ovf_vec;

   div_side_type        dside_ff [QUO_W];
   logic [QUO_W-1:0]    quo [NDIV];

   // Stages after the divide.
   tail_side_type       b2_side_ff, b3_side_ff, b4_side_ff, b5_side_ff, b6_side_ff;
   logic signed [COORD_W-1:0] coord_ff [NDIV];
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff;
   logic [DIFF_W-1:0]   dxm, dym;
   logic [DMAG_W-1:0]   mx_ff, my_ff;
   logic [SQR_W-1:0]    sqx_ff, sqy_ff;
   logic [SQ_IN_W-1:0]  sum_ff;

   // Square root stages.
   tail_side_type       sside_ff [ROOT_W];
   logic [SREM_W-1:0]   srem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   sroot_ff [ROOT_W];
   logic [SQ_IN_W-1:0]  sval_ff  [ROOT_W];

   // Result register.
   logic                out_valid_ff;
   logic [DIST_W-1:0]   out_dist_ff;
   logic                out_degen_ff;
   logic                out_sat_ff;
   logic [RND_W-1:0]    rounded;
   tail_side_type       last_side;

   // The whole back end advances when the result register can take a new value.
   assign en  = !out_valid_ff || rsp_tready;
   assign pop = en && !q_empty;

   assign num_sel[0] = head_data.nxa;
   assign num_sel[1] = head_data.nya;
   assign num_sel[2] = head_data.nxb;
   assign num_sel[3] = head_data.nyb;
   assign den_sel[0] = head_data.wa;
   assign den_sel[1] = head_data.wa;
   assign den_sel[2] = head_data.wb;
   assign den_sel[3] = head_data.wb;

   // B0 and B1 payload.
   always_ff @(posedge clock) begin
      if (en) begin
         b0_degen_ff <= head_data.degen;
         for (int i = 0; i < NDIV; i++) begin
            nmag_ff[i]  <= num_mag(num_sel[i]);
            dmag_ff[i]  <= num_mag(den_sel[i]);
            neg_ff[i]   <= num_sel[i][NUM_W-1] ^ den_sel[i][NUM_W-1];
            rinit_ff[i] <= MAG_W'(nmag_ff[i][MAG_W-1:QI_W]);
            low_ff[i]   <= {nmag_ff[i][QI_W-1:0], FRAC_W'(0)};
            dden_ff[i]  <= dmag_ff[i];
         end
      end
   end

   // An integer part of 2^30 or more means the numerator reaches den * 2^30.
   always_comb begin
      for (int i = 0; i < NDIV; i++) begin
         ovf_vec[i] = (MAG_W'(nmag_ff[i][MAG_W-1:QI_W]) >= dmag_ff[i]);
      end
   end

   // Valid and status for the early stages and alongside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_side_ff  <= '0;
         for (int k = 0; k < QUO_W; k++) dside_ff[k] <= '0;
      end else if (en) begin
         b0_valid_ff      <= !q_empty;
         b1_side_ff.valid <= b0_valid_ff;
         b1_side_ff.degen <= b0_degen_ff;
         b1_side_ff.ovf   <= |ovf_vec;
         b1_side_ff.neg   <= neg_ff;
         dside_ff[0]      <= b1_side_ff;
         for (int k = 1; k < QUO_W; k++) dside_ff[k] <= dside_ff[k-1];
      end
   end

   // Four dividers, one for each mapped coordinate.
   for (genvar i = 0; i < NDIV; i++) begin : g_div
      hpd_div u_div (
         .clock    (clock),
         .en       (en),
         .rem_init (rinit_ff[i]),
         .low_bits (low_ff[i]),
         .den      (dden_ff[i]),
         .quo      (quo[i])
      );
   end

   // Magnitudes of the coordinate differences.
   assign dxm = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign dym = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);

   // B2 through B6: signed coordinates, differences, magnitudes, squares, sum.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NDIV; i++) begin
            coord_ff[i] <= dside_ff[QUO_W-1].neg[i] ? -$signed({1'b0, quo[i]})
                                                    :  $signed({1'b0, quo[i]});
         end
         dx_ff  <= DIFF_W'(coord_ff[2]) - DIFF_W'(coord_ff[0]);
         dy_ff  <= DIFF_W'(coord_ff[3]) - DIFF_W'(coord_ff[1]);
         mx_ff  <= dxm[DMAG_W-1:0];
         my_ff  <= dym[DMAG_W-1:0];
         sqx_ff <= mx_ff * mx_ff;
         sqy_ff <= my_ff * my_ff;
         sum_ff <= SQ_IN_W'(sqx_ff) + SQ_IN_W'(sqy_ff);
      end
   end

   // Status through B2 to B6; a large difference saturates.
   always_ff @(posedge clock) begin
      if (reset) begin
         b2_side_ff <= '0;
         b3_side_ff <= '0;
         b4_side_ff <= '0;
         b5_side_ff <= '0;
         b6_side_ff <= '0;
      end else if (en) begin
         b2_side_ff.valid <= dside_ff[QUO_W-1].valid;
         b2_side_ff.degen <= dside_ff[QUO_W-1].degen;
         b2_side_ff.sat   <= dside_ff[QUO_W-1].ovf;
         b3_side_ff       <= b2_side_ff;
         b4_side_ff.valid <= b3_side_ff.valid;
         b4_side_ff.degen <= b3_side_ff.degen;
         b4_side_ff.sat   <= b3_side_ff.sat || (|dxm[DIFF_W-1:DMAG_W])
                                            || (|dym[DIFF_W-1:DMAG_W]);
         b5_side_ff       <= b4_side_ff;
         b6_side_ff       <= b5_side_ff;
      end
   end

   // Square root, one result bit per stage.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [SREM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0]  root_prev;
      logic [SQ_IN_W-1:0] val_prev;
      tail_side_type      side_prev;
      logic [SREM_W+1:0]  r_try;
      logic [SREM_W+1:0]  trial;
      logic [SREM_W+1:0]  r_sub;
      logic               ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign val_prev  = sum_ff;
         assign side_prev = b6_side_ff;
      end else begin : g_next
         assign rem_prev  = srem_ff[k-1];
         assign root_prev = sroot_ff[k-1];
         assign val_prev  = sval_ff[k-1];
         assign side_prev = sside_ff[k-1];
      end

      assign r_try = {rem_prev, val_prev[SQ_IN_W-1 -: 2]};
      assign trial = (SREM_W+2)'({root_prev, 2'b01});
      assign r_sub = r_try - trial;
      assign ge    = (r_try >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            srem_ff[k]  <= ge ? r_sub[SREM_W-1:0] : r_try[SREM_W-1:0];
            sroot_ff[k] <= {root_prev[ROOT_W-2:0], ge};
            sval_ff[k]  <= val_prev << 2;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sside_ff[k] <= '0;
         end else if (en) begin
            sside_ff[k] <= side_prev;
         end
      end
   end

   // Round Q.12 root to Q.8.
   assign last_side = sside_ff[ROOT_W-1];
   assign rounded   = (RND_W'(sroot_ff[ROOT_W-1]) + RND_W'(8)) >> RND_SH;

   // Result register: zero denominator first, then any saturation.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= last_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (last_side.degen) begin
            out_dist_ff  <= '0;
            out_degen_ff <= 1'b1;
            out_sat_ff   <= 1'b0;
         end else if (last_side.sat || (|rounded[RND_W-1:DIST_W])) begin
            out_dist_ff  <= DIST_MAX;
            out_degen_ff <= 1'b0;
            out_sat_ff   <= 1'b1;
         end else begin
            out_dist_ff  <= rounded[DIST_W-1:0];
            out_degen_ff <= 1'b0;
            out_sat_ff   <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_dist_ff;
   assign rsp_tuser  = {out_sat_ff, out_degen_ff};

endmodule

/* rtl/homography_point_distance.sv */
// Top level of the homography point distance block.
// Each request carries two image points; both are mapped through the programmed
// 3x3 homography and one response gives the distance between the mapped points.
// A new request can be taken every clock cycle while nothing stalls. A request
// passes 82 register stages, the first loaded at the accepting edge: two front
// stages, one queue entry, two operand stages, 42 stages of the four parallel
// one-bit-per-stage coordinate dividers, five difference and square stages, 29
// stages of the square root and the result register. While a response waits on
// rsp_tready the whole back end holds; the four-entry queue then fills and the
// front stops taking requests. The eight coefficients reset to zero; the user must
// write them through the csr port only while idle; the block does not enforce it.
module homography_point_distance (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [hpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hpd_pkg::COEF_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // first_x [19:0], first_y [39:20], second_x [59:40], second_y [79:60]
   input  logic [hpd_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // distance_mm [23:0]
   output logic [hpd_pkg::DIST_W-1:0]    rsp_tdata,
   // degenerate [0], saturated [1]
   output logic [1:0]                    rsp_tuser
);
   import hpd_pkg::*;

   logic      push_valid;
   entry_type push_data;
   logic      q_full;
   logic      pop;
   entry_type head_data;
   logic      q_empty;

   hpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full)
   );

   hpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .q_full     (q_full),
      .pop        (pop),
      .head_data  (head_data),
      .q_empty    (q_empty)
   );

   hpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
